// ----- sv/btra_pkg.sv -----
// Shared types and constants for the block transfer receiver.
`timescale 1ns / 1ps

package btra_pkg;

    localparam logic [15:0] MAX_BLOCK_BYTES = 16'd4095;
    localparam logic [5:0]  WIN_MAX         = 6'd63;
    localparam logic [15:0] EXP_RESET       = 16'd1;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_GAP       = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_MALFORMED = 3'd5
    } t_status;

endpackage

// ----- sv/btra_if.sv -----
// Channel interfaces for block headers, results and the capacity write.
`timescale 1ns / 1ps

interface btra_hdr_if;
    logic        valid;
    logic        ready;
    logic        malformed;
    logic [15:0] blk_num;
    logic [5:0]  window;
    logic        is_last;
    logic [11:0] data_length;

    modport source (output valid, malformed, blk_num, window, is_last, data_length,
                    input ready);
    modport sink (input valid, malformed, blk_num, window, is_last, data_length,
                  output ready);
endinterface

interface btra_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        ack_valid;
    logic [5:0]  ack_window;
    logic [15:0] ack_number;
    logic [15:0] payload_offset;
    logic [15:0] apdu_length;

    modport source (output valid, status, ack_valid, ack_window, ack_number,
                    payload_offset, apdu_length, input ready);
    modport sink (input valid, status, ack_valid, ack_window, ack_number,
                  payload_offset, apdu_length, output ready);
endinterface

interface btra_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- sv/block_transfer_receiver_ack.sv -----
// Top level of the block transfer receiver with acknowledge generation.
`timescale 1ns / 1ps

// Takes one decoded block header per request and returns one result per header.
// A header is held in an input register and decided into the output register once
// that register is empty or its result is taken; the decision also updates the expected
// block number, peer window and accumulated length. A new header is accepted every cycle
// while results are taken, so the throughput is one header per cycle.
// The capacity register is written through its own channel, which is always ready.
module block_transfer_receiver_ack (
    input  logic      i_clk,
    input  logic      i_rst_n,
    btra_hdr_if.sink  i_hdr,
    btra_cfg_if.sink  i_cfg,
    btra_res_if.source o_res
);
    import btra_pkg::*;

    logic        r_in_valid;
    logic        r_in_malformed;
    logic [15:0] r_in_blk_num;
    logic [5:0]  r_in_window;
    logic        r_in_is_last;
    logic [11:0] r_in_data_length;

    logic [15:0] r_apdu_capacity;
    logic [15:0] r_expected_number;
    logic [5:0]  r_peer_win_size;
    logic [15:0] r_accumulated_length;

    logic        r_out_valid;
    t_status     r_status;
    logic        r_ack_valid;
    logic [5:0]  r_ack_window;
    logic [15:0] r_ack_number;
    logic [15:0] r_payload_offset;
    logic [15:0] r_apdu_length;

    t_status     n_status;
    logic        n_ack_valid;
    logic [5:0]  n_ack_window;
    logic [15:0] n_ack_number;
    logic [15:0] n_payload_offset;
    logic [15:0] n_apdu_length;
    logic [15:0] n_expected_number;
    logic [5:0]  n_peer_win_size;
    logic [15:0] n_accumulated_length;

    logic        advance;
    logic [15:0] gap;
    logic [5:0]  dup_window;
    logic [5:0]  new_peer;
    logic [16:0] sum_length;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_hdr.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    assign gap        = r_in_blk_num - r_expected_number;
    assign dup_window = (r_in_window != 6'd0) ? r_in_window : r_peer_win_size;
    assign new_peer   = dup_window;
    assign sum_length = {1'b0, r_accumulated_length} + {5'd0, r_in_data_length};

    always_comb begin
        n_status             = ST_ACCEPTED;
        n_ack_valid          = 1'b0;
        n_ack_window         = 6'd0;
        n_ack_number         = 16'd0;
        n_payload_offset     = 16'd0;
        n_apdu_length        = r_accumulated_length;
        n_expected_number    = r_expected_number;
        n_peer_win_size      = r_peer_win_size;
        n_accumulated_length = r_accumulated_length;
        if (r_in_malformed || ({4'd0, r_in_data_length} > MAX_BLOCK_BYTES)) begin
            n_status             = ST_MALFORMED;
            n_expected_number    = EXP_RESET;
            n_peer_win_size      = 6'd0;
            n_accumulated_length = 16'd0;
        end else if (r_in_blk_num > r_expected_number) begin
            n_status     = ST_GAP;
            n_ack_valid  = 1'b1;
            n_ack_window = (gap > {10'd0, WIN_MAX}) ? WIN_MAX : gap[5:0];
            if (n_ack_window == 6'd0) begin
                n_ack_window = 6'd1;
            end
            n_ack_number = (r_expected_number != 16'd0) ? r_expected_number - 16'd1 : 16'd0;
        end else if (r_in_blk_num < r_expected_number) begin
            n_status = ST_DUPLICATE;
            if (dup_window != 6'd0) begin
                n_ack_valid  = 1'b1;
                n_ack_window = dup_window;
                n_ack_number = r_in_blk_num;
            end
        end else begin
            n_peer_win_size = new_peer;
            if (sum_length > {1'b0, r_apdu_capacity}) begin
                n_status             = ST_OVERFLOW;
                n_expected_number    = EXP_RESET;
                n_peer_win_size      = 6'd0;
                n_accumulated_length = 16'd0;
            end else begin
                n_payload_offset = r_accumulated_length;
                n_apdu_length    = sum_length[15:0];
                if (r_in_is_last) begin
                    n_status             = ST_COMPLETE;
                    n_expected_number    = EXP_RESET;
                    n_peer_win_size      = 6'd0;
                    n_accumulated_length = 16'd0;
                end else begin
                    n_status             = ST_ACCEPTED;
                    n_accumulated_length = sum_length[15:0];
                    n_expected_number    = r_expected_number + 16'd1;
                    if (new_peer != 6'd0) begin
                        n_ack_valid  = 1'b1;
                        n_ack_window = new_peer;
                        n_ack_number = r_expected_number;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
            r_apdu_capacity      <= 16'hFFFF;
            r_expected_number    <= EXP_RESET;
            r_peer_win_size      <= 6'd0;
            r_accumulated_length <= 16'd0;
        end else begin
            if (i_cfg.valid) begin
                r_apdu_capacity <= i_cfg.data;
            end
            if (i_hdr.valid && i_hdr.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid          <= 1'b1;
                r_expected_number    <= n_expected_number;
                r_peer_win_size      <= n_peer_win_size;
                r_accumulated_length <= n_accumulated_length;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hdr.valid && i_hdr.ready) begin
            r_in_malformed   <= i_hdr.malformed;
            r_in_blk_num     <= i_hdr.blk_num;
            r_in_window      <= i_hdr.window;
            r_in_is_last     <= i_hdr.is_last;
            r_in_data_length <= i_hdr.data_length;
        end
        if (advance) begin
            r_status         <= n_status;
            r_ack_valid      <= n_ack_valid;
            r_ack_window     <= n_ack_window;
            r_ack_number     <= n_ack_number;
            r_payload_offset <= n_payload_offset;
            r_apdu_length    <= n_apdu_length;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_status;
    assign o_res.ack_valid      = r_ack_valid;
    assign o_res.ack_window     = r_ack_window;
    assign o_res.ack_number     = r_ack_number;
    assign o_res.payload_offset = r_payload_offset;
    assign o_res.apdu_length    = r_apdu_length;

endmodule

// ----- sv/btra_checker.sv -----
// Port-level assertions for the block transfer receiver and their bind.
`timescale 1ns / 1ps

module btra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic        i_ack_valid,
    input logic [5:0]  i_ack_window,
    input logic [15:0] i_ack_number,
    input logic [15:0] i_payload_offset
);
    import btra_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_ack_number))
        else $error("stalled result changed");

    a_no_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ack_valid |-> i_ack_window == 6'd0 && i_ack_number == 16'd0)
        else $error("acknowledge fields set without acknowledge");

    a_gap_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_GAP |-> i_ack_valid && i_ack_window != 6'd0)
        else $error("gap without retransmission request");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_ACCEPTED && i_status != ST_COMPLETE
            |-> i_payload_offset == 16'd0 && (i_status != ST_MALFORMED || !i_ack_valid))
        else $error("offset or acknowledge on a rejected block");

endmodule

bind block_transfer_receiver_ack btra_checker u_btra_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_status         (o_res.status),
    .i_ack_valid      (o_res.ack_valid),
    .i_ack_window     (o_res.ack_window),
    .i_ack_number     (o_res.ack_number),
    .i_payload_offset (o_res.payload_offset)
);

// ----- sim/tb_block_transfer_receiver_ack.sv -----
// Self-checking testbench for the block transfer receiver with acknowledge generation.
`timescale 1ns / 1ps

module tb_block_transfer_receiver_ack;
    import btra_pkg::*;

    typedef struct packed {
        logic        malformed;
        logic [15:0] blk_num;
        logic [5:0]  window;
        logic        is_last;
        logic [11:0] data_length;
    } t_block_hdr;

    typedef struct packed {
        t_status     status;
        logic        ack_valid;
        logic [5:0]  ack_window;
        logic [15:0] ack_number;
        logic [15:0] payload_offset;
        logic [15:0] apdu_length;
    } t_verdict;

    typedef enum bit {
        ROW_HDR,
        ROW_CAP
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] capacity;
        t_block_hdr  hdr;
        logic        typed;
        t_verdict    want;
    } t_plan_row;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 134;
    localparam t_block_hdr NO_HDR = '{1'b0, 16'd0, 6'd0, 1'b0, 12'd0};
    localparam t_verdict NO_VERDICT = '{ST_ACCEPTED, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0};

    localparam t_plan_row DIRECTED_PLAN [0:20] = '{
        '{ROW_HDR, 16'd0, '{1'b1, 16'd1, 6'd63, 1'b1, 12'd4095}, 1'b1,
          '{ST_MALFORMED, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0}},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd1, 6'd0, 1'b0, 12'd0}, 1'b1,
          '{ST_ACCEPTED, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0}},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd2, 6'd63, 1'b0, 12'd4095}, 1'b1,
          '{ST_ACCEPTED, 1'b1, 6'd63, 16'd2, 16'd0, 16'd4095}},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd65535, 6'd0, 1'b0, 12'd0}, 1'b1,
          '{ST_GAP, 1'b1, 6'd63, 16'd2, 16'd0, 16'd4095}},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd4, 6'd0, 1'b0, 12'd0}, 1'b1,
          '{ST_GAP, 1'b1, 6'd1, 16'd2, 16'd0, 16'd4095}},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd0, 6'd0, 1'b0, 12'd0}, 1'b1,
          '{ST_DUPLICATE, 1'b1, 6'd63, 16'd0, 16'd0, 16'd4095}},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd2, 6'd5, 1'b0, 12'd0}, 1'b1,
          '{ST_DUPLICATE, 1'b1, 6'd5, 16'd2, 16'd0, 16'd4095}},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd3, 6'd1, 1'b1, 12'd4095}, 1'b1,
          '{ST_COMPLETE, 1'b0, 6'd0, 16'd0, 16'd4095, 16'd8190}},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd0, 6'd0, 1'b0, 12'd0}, 1'b1,
          '{ST_DUPLICATE, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0}},
        '{ROW_CAP, 16'd0, NO_HDR, 1'b0, NO_VERDICT},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd1, 6'd0, 1'b0, 12'd1}, 1'b1,
          '{ST_OVERFLOW, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0}},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd1, 6'd0, 1'b1, 12'd0}, 1'b1,
          '{ST_COMPLETE, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0}},
        '{ROW_CAP, 16'd100, NO_HDR, 1'b0, NO_VERDICT},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd1, 6'd3, 1'b0, 12'd60}, 1'b1,
          '{ST_ACCEPTED, 1'b1, 6'd3, 16'd1, 16'd0, 16'd60}},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd2, 6'd0, 1'b0, 12'd40}, 1'b1,
          '{ST_ACCEPTED, 1'b1, 6'd3, 16'd2, 16'd60, 16'd100}},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd3, 6'd0, 1'b1, 12'd1}, 1'b1,
          '{ST_OVERFLOW, 1'b0, 6'd0, 16'd0, 16'd0, 16'd100}},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd1, 6'd7, 1'b0, 12'd0}, 1'b0, NO_VERDICT},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd2, 6'd0, 1'b0, 12'd12}, 1'b0, NO_VERDICT},
        '{ROW_HDR, 16'd0, '{1'b1, 16'd2, 6'd0, 1'b0, 12'd0}, 1'b1,
          '{ST_MALFORMED, 1'b0, 6'd0, 16'd0, 16'd0, 16'd12}},
        '{ROW_HDR, 16'd0, '{1'b0, 16'd100, 6'd0, 1'b0, 12'd0}, 1'b1,
          '{ST_GAP, 1'b1, 6'd63, 16'd0, 16'd0, 16'd0}},
        '{ROW_CAP, 16'd65535, NO_HDR, 1'b0, NO_VERDICT}
    };

    logic i_clk;
    logic i_rst_n;

    btra_hdr_if hdr();
    btra_cfg_if cfg();
    btra_res_if res();

    block_transfer_receiver_ack dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (hdr),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    logic [15:0] next_block;
    logic [5:0]  peer_win;
    logic [15:0] held_length;
    logic [15:0] buffer_size;

    t_verdict expected_verdicts[$];
    int error_count = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic void clear_progress();
        next_block = EXP_RESET;
        peer_win = 6'd0;
        held_length = 16'd0;
    endfunction

    function automatic t_verdict decide_block(input t_block_hdr h);
        t_verdict r;
        logic [16:0] sum;
        logic [15:0] gap;
        logic [5:0] w;
        r = '{ST_ACCEPTED, 1'b0, 6'd0, 16'd0, 16'd0, held_length};
        sum = {1'b0, held_length} + 17'(h.data_length);
        if (h.malformed || 16'(h.data_length) > MAX_BLOCK_BYTES) begin
            r.status = ST_MALFORMED;
            clear_progress();
        end else if (h.blk_num > next_block) begin
            gap = h.blk_num - next_block;
            r.status = ST_GAP;
            r.ack_valid = 1'b1;
            r.ack_window = (gap > 16'(WIN_MAX)) ? WIN_MAX : gap[5:0];
            if (r.ack_window == 6'd0) begin
                r.ack_window = 6'd1;
            end
            r.ack_number = (next_block == 16'd0) ? 16'd0 : next_block - 16'd1;
        end else if (h.blk_num < next_block) begin
            w = (h.window != 6'd0) ? h.window : peer_win;
            r.status = ST_DUPLICATE;
            if (w != 6'd0) begin
                r.ack_valid = 1'b1;
                r.ack_window = w;
                r.ack_number = h.blk_num;
            end
        end else begin
            if (h.window != 6'd0) begin
                peer_win = h.window;
            end
            if (sum > {1'b0, buffer_size}) begin
                r.status = ST_OVERFLOW;
                clear_progress();
            end else begin
                r.payload_offset = held_length;
                r.apdu_length = sum[15:0];
                if (h.is_last) begin
                    r.status = ST_COMPLETE;
                    clear_progress();
                end else begin
                    held_length = sum[15:0];
                    if (peer_win != 6'd0) begin
                        r.ack_valid = 1'b1;
                        r.ack_window = peer_win;
                        r.ack_number = next_block;
                    end
                    next_block = next_block + 16'd1;
                end
            end
        end
        return r;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic send_hdr(input t_block_hdr h, input logic typed, input t_verdict want);
        t_verdict predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            hdr.valid <= 1'b0;
            @(posedge i_clk);
        end
        hdr.valid <= 1'b1;
        hdr.malformed <= h.malformed;
        hdr.blk_num <= h.blk_num;
        hdr.window <= h.window;
        hdr.is_last <= h.is_last;
        hdr.data_length <= h.data_length;
        do @(posedge i_clk); while (!hdr.ready);
        predicted = decide_block(h);
        expected_verdicts.push_back(typed ? want : predicted);
    endtask

    task automatic drain();
        hdr.valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [15:0] value);
        drain();
        cfg.valid <= 1'b1;
        cfg.data <= value;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        buffer_size = value;
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_block_transfer_receiver_ack NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                got = {res.status, res.ack_valid, res.ack_window, res.ack_number,
                       res.payload_offset, res.apdu_length};
                if (expected_verdicts.size() == 0) begin
                    flag_error("result with no request pending");
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got !== want) begin
                        flag_error($sformatf(
                            "got %0d/%0d/%0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d/%0d/%0d",
                            got.status, got.ack_valid, got.ack_window, got.ack_number,
                            got.payload_offset, got.apdu_length, want.status,
                            want.ack_valid, want.ack_window, want.ack_number,
                            want.payload_offset, want.apdu_length));
                    end
                end
            end
            res.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        t_block_hdr h;
        int sel;
        i_rst_n = 1'b0;
        hdr.valid = 1'b0;
        hdr.malformed = 1'b0;
        hdr.blk_num = 16'd0;
        hdr.window = 6'd0;
        hdr.is_last = 1'b0;
        hdr.data_length = 12'd0;
        cfg.valid = 1'b0;
        cfg.data = 16'd0;
        res.ready = 1'b0;
        buffer_size = 16'hFFFF;
        clear_progress();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 27;
        rx_stall_pct = 62;
        for (int i = 0; i < $size(DIRECTED_PLAN); i++) begin
            if (DIRECTED_PLAN[i].kind == ROW_CAP) begin
                set_capacity(DIRECTED_PLAN[i].capacity);
            end else begin
                send_hdr(DIRECTED_PLAN[i].hdr, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
            end
        end

        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = (p == 0) ? 27 : (p == 1) ? 62 : 0;
            rx_stall_pct = (p == 0) ? 62 : (p == 1) ? 27 : 0;
            set_capacity((p == 0) ? 16'hFFFF : (p == 1) ? 16'd1500
                                             : 16'($urandom_range(65535)));
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                sel = $urandom_range(99);
                h.malformed = ($urandom_range(24) == 0);
                h.window = ($urandom_range(3) == 0) ? 6'd0 : 6'($urandom_range(63));
                h.is_last = ($urandom_range(11) == 0);
                h.data_length = ($urandom_range(7) == 0) ? 12'($urandom)
                                                         : 12'($urandom_range(400));
                if (sel < 70) begin
                    h.blk_num = next_block;
                end else if (sel < 82) begin
                    h.blk_num = next_block + 16'($urandom_range(80, 1));
                end else if (sel < 92 && next_block != 16'd0) begin
                    h.blk_num = next_block - 16'($urandom_range(int'(next_block), 1));
                end else begin
                    h.blk_num = 16'($urandom);
                end
                send_hdr(h, 1'b0, NO_VERDICT);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_block_transfer_receiver_ack OK");
        end else begin
            $display("tb_block_transfer_receiver_ack NOT OK");
        end
        $finish;
    end

endmodule
